@@ hdl/lin_master_frame_builder_unit_defines.svh @@
// Assertion macros shared by the LIN frame builder RTL.
// Needs clk and rst in scope at the point of use.
`ifndef LIN_MASTER_FRAME_BUILDER_UNIT_DEFINES_SVH
`define LIN_MASTER_FRAME_BUILDER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define LMFB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define LMFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/lmfb_pkg.sv @@
// Package for the LIN master frame builder: widths, constants, state and
// command types, protected identifier helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lmfb_pkg;

  localparam int ID_W            = 6;
  localparam int PAYLOAD_W       = 64;
  localparam int LEN_W           = 4;
  localparam int BYTE_W          = 8;
  localparam int LMFB_MAX_PAYLOAD = 8;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;
  localparam logic [BYTE_W-1:0] CKSUM_INV = 8'hFF;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_SYNC,
    ST_PID,
    ST_DATA,
    ST_CKSUM
  } lmfb_state_t;

  // What the output register is loaded with
  typedef enum logic [2:0] {
    SEL_BREAK,
    SEL_SYNC,
    SEL_PID,
    SEL_DATA,
    SEL_CKSUM,
    SEL_REJECT
  } lmfb_sel_t;

  typedef struct packed {
    logic      load;  // capture the request
    logic      emit;  // load the output register
    lmfb_sel_t sel;
  } lmfb_cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a beat
    logic len_zero;   // header-only frame
    logic len_over;   // length out of range
    logic rem_last;   // one payload byte left
  } lmfb_sts_t;

  // Identifier with P0 in bit 6 and P1 in bit 7
  function automatic logic [BYTE_W-1:0] protect_id(input logic [ID_W-1:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

endpackage

`default_nettype wire

@@ hdl/lmfb_ifs.sv @@
// Valid/ready channel interfaces for frame requests and transmit beats.
// Depends on lmfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lmfb_req_if;
  import lmfb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ID_W-1:0]      frame_id;
  logic [PAYLOAD_W-1:0] payload;
  logic [LEN_W-1:0]     payload_length;

  modport source (output valid, frame_id, payload, payload_length, input ready);
  modport sink   (input valid, frame_id, payload, payload_length, output ready);
endinterface

interface lmfb_rsp_if;
  import lmfb_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              is_break;
  logic              last;
  logic              rejected;

  modport source (output valid, out_byte, is_break, last, rejected, input ready);
  modport sink   (input valid, out_byte, is_break, last, rejected, output ready);
endinterface

`default_nettype wire

@@ hdl/lmfb_ctrl.sv @@
// Frame sequencer: walks header, payload and checksum beats, or a single reject beat, for one request.
// Depends on lmfb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "lin_master_frame_builder_unit_defines.svh"

module lmfb_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               req_valid,
  output logic              req_ready,
  input  wire lmfb_pkg::lmfb_sts_t sts,
  output lmfb_pkg::lmfb_cmd_t cmd
);
  import lmfb_pkg::*;

  lmfb_state_t state;
  lmfb_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_HEAD;
      end
      ST_HEAD: begin
        if (sts.out_free) state_next = sts.len_over ? ST_IDLE : ST_SYNC;
      end
      ST_SYNC: begin
        if (sts.out_free) state_next = ST_PID;
      end
      ST_PID: begin
        if (sts.out_free) state_next = sts.len_zero ? ST_IDLE : ST_DATA;
      end
      ST_DATA: begin
        if (sts.out_free && sts.rem_last) state_next = ST_CKSUM;
      end
      ST_CKSUM: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req_ready = 1'b0;
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    cmd.sel   = SEL_BREAK;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      ST_HEAD: begin
        cmd.emit = sts.out_free;
        cmd.sel  = sts.len_over ? SEL_REJECT : SEL_BREAK;
      end
      ST_SYNC: begin
        cmd.emit = sts.out_free;
        cmd.sel  = SEL_SYNC;
      end
      ST_PID: begin
        cmd.emit = sts.out_free;
        cmd.sel  = SEL_PID;
      end
      ST_DATA: begin
        cmd.emit = sts.out_free;
        cmd.sel  = SEL_DATA;
      end
      ST_CKSUM: begin
        cmd.emit = sts.out_free;
        cmd.sel  = SEL_CKSUM;
      end
      default: begin
        cmd.emit = 1'b0;
      end
    endcase
  end

  // Checks
  `LMFB_ASSERT_NOW(a_emit_has_room, cmd.emit, sts.out_free, "beat emitted into a full output register")
  `LMFB_ASSERT_NEXT(a_load_starts_frame, cmd.load, state == ST_HEAD, "request capture did not start a frame")
  `LMFB_ASSERT_NOW(a_cksum_follows_data, state == ST_CKSUM, $past(state) == ST_DATA || $past(state) == ST_CKSUM, "checksum without payload")

endmodule

`default_nettype wire

@@ hdl/lmfb_dp.sv @@
// Datapath: request registers, payload shifter, running checksum and the
// output register. Depends on lmfb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "lin_master_frame_builder_unit_defines.svh"

module lmfb_dp #(
  parameter int MAX_PAYLOAD = lmfb_pkg::LMFB_MAX_PAYLOAD
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire [lmfb_pkg::ID_W-1:0]            frame_id,
  input  wire [lmfb_pkg::PAYLOAD_W-1:0]       payload,
  input  wire [lmfb_pkg::LEN_W-1:0]           payload_length,
  input  wire lmfb_pkg::lmfb_cmd_t            cmd,
  output lmfb_pkg::lmfb_sts_t                 sts,
  lmfb_rsp_if.source                          rsp
);
  import lmfb_pkg::*;

  logic [BYTE_W-1:0]    pid;
  logic [PAYLOAD_W-1:0] data_sr;
  logic [LEN_W-1:0]     rem;
  logic [BYTE_W-1:0]    sum;
  logic                 len_zero;
  logic                 len_over;

  logic                 ovalid;
  logic [BYTE_W-1:0]    obyte;
  logic                 obrk;
  logic                 olast;
  logic                 orej;

  logic [BYTE_W:0]      sum_raw;
  logic [BYTE_W-1:0]    sum_next;
  logic                 data_step;

  // End-around carry add of the current payload byte
  assign sum_raw   = {1'b0, sum} + {1'b0, data_sr[BYTE_W-1:0]};
  assign sum_next  = sum_raw[BYTE_W-1:0] + {{(BYTE_W-1){1'b0}}, sum_raw[BYTE_W]};
  assign data_step = cmd.emit && (cmd.sel == SEL_DATA);

  // Request registers, shifter and checksum
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pid      <= protect_id(frame_id);
      sum      <= protect_id(frame_id);
      data_sr  <= payload;
      rem      <= payload_length;
      len_zero <= (payload_length == '0);
      len_over <= (payload_length > LEN_W'(MAX_PAYLOAD));
    end else if (data_step) begin
      data_sr <= data_sr >> BYTE_W;
      rem     <= rem - LEN_W'(1);
      sum     <= sum_next;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (cmd.emit) begin
      ovalid <= 1'b1;
    end else if (rsp.ready) begin
      ovalid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      obyte <= '0;
      obrk  <= 1'b0;
      olast <= 1'b0;
      orej  <= 1'b0;
      case (cmd.sel)
        SEL_BREAK:  obrk <= 1'b1;
        SEL_SYNC:   obyte <= SYNC_BYTE;
        SEL_PID: begin
          obyte <= pid;
          olast <= len_zero;
        end
        SEL_DATA:   obyte <= data_sr[BYTE_W-1:0];
        SEL_CKSUM: begin
          obyte <= sum ^ CKSUM_INV;
          olast <= 1'b1;
        end
        SEL_REJECT: begin
          olast <= 1'b1;
          orej  <= 1'b1;
        end
        default: obyte <= '0;
      endcase
    end
  end

  assign rsp.valid    = ovalid;
  assign rsp.out_byte = obyte;
  assign rsp.is_break = obrk;
  assign rsp.last     = olast;
  assign rsp.rejected = orej;

  assign sts.out_free = !ovalid || rsp.ready;
  assign sts.len_zero = len_zero;
  assign sts.len_over = len_over;
  assign sts.rem_last = (rem == LEN_W'(1));

  // Checks
  `LMFB_ASSERT_NOW(a_data_has_bytes, data_step, rem != '0, "payload beat with no bytes left")
  `LMFB_ASSERT_NEXT(a_emit_sets_valid, cmd.emit, ovalid, "emitted beat not presented")
  `LMFB_ASSERT_NOW(a_reject_alone, ovalid && orej, olast && !obrk, "reject beat malformed")

endmodule

`default_nettype wire

@@ hdl/lin_master_frame_builder_unit.sv @@
// Top level of the LIN master frame builder: sequencer plus datapath.
// Depends on lmfb_pkg, lmfb_ifs, lmfb_ctrl and lmfb_dp.
//
//  Channel | Dir | Beat contents
//  --------+-----+-----------------------------------------------
//  req     | in  | frame_id, payload (byte 0 low), payload_length
//  rsp     | out | out_byte, is_break, last, rejected
//
// A request is captured while idle, then one beat per cycle leaves through
// the output register unless rsp stalls: break, sync, PID, the payload
// bytes and checksum for a frame with payload; break, sync and PID for
// header only; one reject beat for an oversize length. The next request is
// taken while the final beat waits. rsp stalls hold the sequencer in place.
// rst is synchronous and clears the sequencer and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module lin_master_frame_builder_unit #(
  parameter int MAX_PAYLOAD = lmfb_pkg::LMFB_MAX_PAYLOAD
) (
  input wire          clk,
  input wire          rst,
  lmfb_req_if.sink    req,
  lmfb_rsp_if.source  rsp
);
  import lmfb_pkg::*;

  lmfb_cmd_t cmd;
  lmfb_sts_t sts;

  lmfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lmfb_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .frame_id       (req.frame_id),
    .payload        (req.payload),
    .payload_length (req.payload_length),
    .cmd            (cmd),
    .sts            (sts),
    .rsp            (rsp)
  );

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for lin_master_frame_builder_unit. It sends frame requests, predicts
// the break/sync/PID/data/checksum beats (or the reject beat) of each frame and checks every output beat in order.
// Depends on lmfb_pkg, lmfb_ifs and the frame builder RTL.
module testbench;
  import lmfb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int BATCH_ITEMS = 135;
  localparam int TAIL_CYCLES = 16;

  typedef struct {
    logic [ID_W-1:0]      frame_id;
    logic [PAYLOAD_W-1:0] payload;
    logic [LEN_W-1:0]     payload_length;
  } frame_req_t;

  typedef struct {
    logic [BYTE_W-1:0] out_byte;
    logic              is_break;
    logic              last;
    logic              rejected;
  } tx_beat_t;

  logic clk;
  logic rst;

  lmfb_req_if req_ch();
  lmfb_rsp_if rsp_ch();

  lin_master_frame_builder_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  frame_req_t frames_to_send[$];
  tx_beat_t   beats_due[$];
  int         tx_idle_pct;
  int         rx_idle_pct;
  int         hold_asks;
  int         hold_served;
  int         hold_left;
  int         mismatches;
  int         cycle_count;
  logic       req_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Identifier with P0 in bit 6 and P1 in bit 7
  function automatic logic [BYTE_W-1:0] pid_of(logic [ID_W-1:0] id);
    logic p0;
    logic p1;
    p0 = ^(id & 6'b01_0111);
    p1 = ~^(id & 6'b11_1010);
    return {p1, p0, id};
  endfunction

  // Queue every beat one request should produce
  function automatic void predict_frame(frame_req_t f);
    logic [BYTE_W-1:0] pid;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W:0]   sum;
    if (f.payload_length > LMFB_MAX_PAYLOAD) begin
      beats_due.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
      return;
    end
    pid = pid_of(f.frame_id);
    beats_due.push_back('{8'h00, 1'b1, 1'b0, 1'b0});
    beats_due.push_back('{SYNC_BYTE, 1'b0, 1'b0, 1'b0});
    beats_due.push_back('{pid, 1'b0, (f.payload_length == 0), 1'b0});
    if (f.payload_length == 0)
      return;
    // enhanced checksum: end-around-carry sum over PID and data
    sum = {1'b0, pid};
    for (int i = 0; i < f.payload_length; i++) begin
      data_byte = f.payload[8*i +: 8];
      sum = sum + {1'b0, data_byte};
      if (sum >= 9'd256)
        sum = sum - 9'd255;
      beats_due.push_back('{data_byte, 1'b0, 1'b0, 1'b0});
    end
    beats_due.push_back('{~sum[BYTE_W-1:0], 1'b0, 1'b1, 1'b0});
  endfunction

  function automatic void compare_field(string name, logic [BYTE_W-1:0] want,
                                        logic [BYTE_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Request driver: new beat only when the last one was taken or none was offered
  always @(negedge clk) begin : drive_req
    frame_req_t f;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (frames_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        f = frames_to_send.pop_front();
        req_ch.valid          <= 1'b1;
        req_ch.frame_id       <= f.frame_id;
        req_ch.payload        <= f.payload;
        req_ch.payload_length <= f.payload_length;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response ready: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_served  <= 0;
      hold_left    <= 0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_asks != hold_served) begin
      rsp_ch.ready <= 1'b0;
      hold_served  <= hold_asks;
      hold_left    <= HOLD_CYCLES;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Predict on accepted requests, check accepted beats
  always @(posedge clk) begin : watch
    tx_beat_t want;
    frame_req_t f;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        f.frame_id       = req_ch.frame_id;
        f.payload        = req_ch.payload;
        f.payload_length = req_ch.payload_length;
        predict_frame(f);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (beats_due.size() == 0) begin
          $error("unexpected beat: out_byte %0h is_break %0b last %0b rejected %0b",
                 rsp_ch.out_byte, rsp_ch.is_break, rsp_ch.last, rsp_ch.rejected);
          mismatches++;
        end else begin
          want = beats_due.pop_front();
          compare_field("out_byte", want.out_byte, rsp_ch.out_byte);
          compare_field("is_break", want.is_break, rsp_ch.is_break);
          compare_field("last", want.last, rsp_ch.last);
          compare_field("rejected", want.rejected, rsp_ch.rejected);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic queue_frame(logic [ID_W-1:0] id, logic [PAYLOAD_W-1:0] data,
                             logic [LEN_W-1:0] len);
    frame_req_t f;
    f.frame_id       = id;
    f.payload        = data;
    f.payload_length = len;
    frames_to_send.push_back(f);
  endtask

  // Mostly legal lengths, some header-only and some oversize requests
  task automatic queue_random(int count);
    int pick;
    logic [LEN_W-1:0]     len;
    logic [PAYLOAD_W-1:0] data;
    @(posedge clk);
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 8)
        len = '0;
      else if (pick < 20)
        len = LEN_W'($urandom_range(15, LMFB_MAX_PAYLOAD + 1));
      else
        len = LEN_W'($urandom_range(LMFB_MAX_PAYLOAD, 1));
      data = {$urandom, $urandom};
      if ($urandom_range(9) == 0)
        data = '1;
      queue_frame(ID_W'($urandom_range(63)), data, len);
    end
  endtask

  // Returns once nothing is queued, offered or outstanding
  task automatic wait_drained();
    do
      @(posedge clk);
    while (frames_to_send.size() != 0 || beats_due.size() != 0 || req_ch.valid);
  endtask

  initial begin
    req_ch.valid          = 1'b0;
    req_ch.frame_id       = '0;
    req_ch.payload        = '0;
    req_ch.payload_length = '0;
    rsp_ch.ready          = 1'b0;
    tx_idle_pct = 24;
    rx_idle_pct = 51;
    hold_asks   = 0;
    mismatches  = 0;
    cycle_count = 0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);

    // Directed: header only, full frames, carries, rejects, parity bits
    queue_frame(6'd0, 64'h0, 4'd0);
    queue_frame(6'd63, '1, 4'd0);
    queue_frame(6'd0, '1, 4'd8);
    queue_frame(6'd63, '1, 4'd8);
    queue_frame(6'h3c, 64'h0, 4'd8);
    queue_frame(6'h2a, '1, 4'd1);          // bytes past the length ignored
    queue_frame(6'd0, 64'h7f, 4'd1);       // checksum comes out zero
    queue_frame(6'd63, '1, 4'd9);
    queue_frame(6'd17, 64'h1234, 4'd15);
    queue_frame(6'd5, 64'h0, 4'd12);
    queue_frame(6'd1, 64'h0000_0000_00c0_ff80, 4'd3);
    queue_frame(6'd2, 64'h0000_0000_0001_80ff, 4'd2);
    queue_frame(6'd4, 64'hdead_beef_0102_0304, 4'd4);
    queue_frame(6'd8, 64'haa55_aa55_aa55_aa55, 4'd5);
    queue_frame(6'd16, 64'h55aa_55aa_55aa_55aa, 4'd6);
    queue_frame(6'd32, 64'h8080_8080_8080_8080, 4'd7);
    queue_frame(6'h15, 64'h0123_4567_89ab_cdef, 4'd8);
    queue_frame(6'h2a, 64'hfedc_ba98_7654_3210, 4'd8);
    queue_frame(6'h3f, 64'h0101_0101_0101_0101, 4'd8);

    hold_asks++;
    queue_random(BATCH_ITEMS);
    wait_drained();   // sender pauses until every beat is back

    tx_idle_pct = 51;
    rx_idle_pct = 24;
    queue_random(BATCH_ITEMS);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_asks++;
    queue_random(BATCH_ITEMS);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && beats_due.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/lmfb_pkg.sv
hdl/lmfb_ifs.sv
hdl/lmfb_ctrl.sv
hdl/lmfb_dp.sv
hdl/lin_master_frame_builder_unit.sv
test/testbench.sv
